// ===== hw/rtl/bcut_pkg.sv =====
// ----------------------------------------------------------------------------
// bcut_pkg
// Shared types, character codes and a helper for the byte count text
// formatter.
// ----------------------------------------------------------------------------
package bcut_pkg;

  // Default depth of the queue between the classifier and the serializer.
  localparam int FMT_QUEUE_DEPTH = 4;

  // Number of decimal digit slots (quotient never exceeds 1023).
  localparam int NUM_DIGITS = 4;

  // ASCII codes used in the text.
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_K     = 8'h4B;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_G     = 8'h47;

  typedef enum logic [1:0] {
    UNIT_B = 2'd0,
    UNIT_K = 2'd1,
    UNIT_M = 2'd2,
    UNIT_G = 2'd3
  } unit_t;

  // One classified request: BCD digits (thousands first), digit count, unit.
  typedef struct packed {
    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [2:0]                 ndig;
    unit_t                      unit;
  } fmt_item_t;

  // Prefix letter of a unit; plain bytes carry none, so they fall back to 'B'.
  function automatic logic [7:0] unit_letter(input unit_t unit);
    logic [7:0] ch;
    case (unit)
      UNIT_K:  ch = CHAR_K;
      UNIT_M:  ch = CHAR_M;
      UNIT_G:  ch = CHAR_G;
      default: ch = CHAR_B;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/byte_count_to_unit_text.sv =====
// ----------------------------------------------------------------------------
// byte_count_to_unit_text
// Path: four front stages, then the queue, then the output register.
// Throughput: one character per cycle while pop is held and the queue is
// not empty; a request yields 3 to 7 characters.
// Reset: synchronous rst clears the pipeline, the queue and the output.
// ----------------------------------------------------------------------------
//
// Formats a 32-bit byte count as ASCII text such as "512 MB" or "0 B".
//
// Front: picks the largest unit whose threshold the count reaches
// (2^30 for GB, 2^20 for MB, 2^10 for KB, else bytes), shifts the count
// down to a quotient of at most 1023 and splits it into decimal digits.
// The digit split runs over four registered stages with reciprocal
// multiplies, so the front takes a request every cycle unless the queue fills.
//
// Queue: holds classified requests so the front keeps working while the
// serializer is busy or the consumer stalls.
//
// Back: emits the digits without leading zeros, then a space, the unit
// letter if any, and 'B'. The last character of a request is flagged.
// The output register lets the next character be prepared while the
// current one waits for pop.
// ----------------------------------------------------------------------------
module byte_count_to_unit_text #(
  parameter int QueueDepth = bcut_pkg::FMT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] byte_count,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  text_char,
  output logic        last_char
);
  import bcut_pkg::*;

  // Classified requests from the front into the queue.
  logic      fq_push;
  logic      fq_full;
  fmt_item_t fq_item;

  // Head of the queue toward the serializer.
  logic      bq_pop;
  logic      bq_empty;
  fmt_item_t bq_item;

  // Classify and split into digits.
  bcut_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .byte_count (byte_count),
    .q_push     (fq_push),
    .q_full     (fq_full),
    .q_item     (fq_item)
  );

  // Decouple the two halves.
  bcut_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .full  (fq_full),
    .wdata (fq_item),
    .pop   (bq_pop),
    .empty (bq_empty),
    .rdata (bq_item)
  );

  // Serialize into characters.
  bcut_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (bq_empty),
    .q_item    (bq_item),
    .q_pop     (bq_pop),
    .pop       (pop),
    .empty     (empty),
    .text_char (text_char),
    .last_char (last_char)
  );

endmodule

// ===== hw/rtl/bcut_front.sv =====
// ----------------------------------------------------------------------------
// bcut_front
// Pick the unit, shift the count down and split the quotient into decimal
// digits over a four-stage pipeline.
// ----------------------------------------------------------------------------
module bcut_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         byte_count,
  output logic                q_push,
  input  logic                q_full,
  output bcut_pkg::fmt_item_t q_item
);
  import bcut_pkg::*;

  logic       v1, v2, v3, v4;
  logic       adv1, adv2, adv3, adv4;
  logic       in_acc;

  unit_t      in_unit;
  logic [9:0] in_value;

  unit_t      unit1, unit2, unit3, unit4;
  logic       thou1, thou2, thou3, thou4;
  logic [9:0] r1_1, r1_2;
  logic [3:0] hund2, hund3, hund4;
  logic [6:0] r2_3, r2_4;
  logic [3:0] tens4;

  logic [15:0] hund_prod;
  logic [9:0]  hund_sub;
  logic [9:0]  r2_wide;
  logic [14:0] tens_prod;
  logic [6:0]  tens_sub;
  logic [6:0]  ones_wide;

  assign adv4   = v4 && !q_full;
  assign adv3   = v3 && (!v4 || adv4);
  assign adv2   = v2 && (!v3 || adv3);
  assign adv1   = v1 && (!v2 || adv2);
  assign full   = v1 && !(!v2 || adv2);
  assign in_acc = push && !full;

  // Classify: the highest nonzero group (31:30, 29:20, 19:10) sets the unit.
  always_comb begin
    if (byte_count[31:30] != 2'd0) begin
      in_unit  = UNIT_G;
      in_value = {8'd0, byte_count[31:30]};
    end else if (byte_count[29:20] != 10'd0) begin
      in_unit  = UNIT_M;
      in_value = byte_count[29:20];
    end else if (byte_count[19:10] != 10'd0) begin
      in_unit  = UNIT_K;
      in_value = byte_count[19:10];
    end else begin
      in_unit  = UNIT_B;
      in_value = byte_count[9:0];
    end
  end

  // Hundreds digit as (r * 41) >> 12, exact for r below 1000.
  assign hund_prod = {6'd0, r1_1} * 16'd41;
  assign hund_sub  = 10'(hund2) * 10'd100;
  assign r2_wide   = r1_2 - hund_sub;
  // Tens digit as (r * 205) >> 11, exact for r below 100.
  assign tens_prod = {8'd0, r2_3} * 15'd205;
  assign tens_sub  = 7'(tens4) * 7'd10;
  assign ones_wide = r2_4 - tens_sub;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= in_acc ? 1'b1 : (adv1 ? 1'b0 : v1);
      v2 <= adv1   ? 1'b1 : (adv2 ? 1'b0 : v2);
      v3 <= adv2   ? 1'b1 : (adv3 ? 1'b0 : v3);
      v4 <= adv3   ? 1'b1 : (adv4 ? 1'b0 : v4);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      unit1 <= in_unit;
      thou1 <= (in_value >= 10'd1000);
      r1_1  <= (in_value >= 10'd1000) ? (in_value - 10'd1000) : in_value;
    end
    if (adv1) begin
      unit2 <= unit1;
      thou2 <= thou1;
      r1_2  <= r1_1;
      hund2 <= hund_prod[15:12];
    end
    if (adv2) begin
      unit3 <= unit2;
      thou3 <= thou2;
      hund3 <= hund2;
      r2_3  <= r2_wide[6:0];
    end
    if (adv3) begin
      unit4 <= unit3;
      thou4 <= thou3;
      hund4 <= hund3;
      r2_4  <= r2_3;
      tens4 <= tens_prod[14:11];
    end
  end

  always_comb begin
    q_push           = adv4;
    q_item.digits[0] = {3'd0, thou4};
    q_item.digits[1] = hund4;
    q_item.digits[2] = tens4;
    q_item.digits[3] = ones_wide[3:0];
    q_item.unit      = unit4;
    if (thou4) begin
      q_item.ndig = 3'd4;
    end else if (hund4 != 4'd0) begin
      q_item.ndig = 3'd3;
    end else if (tens4 != 4'd0) begin
      q_item.ndig = 3'd2;
    end else begin
      q_item.ndig = 3'd1;
    end
  end

endmodule

// ===== hw/rtl/bcut_queue.sv =====
// ----------------------------------------------------------------------------
// bcut_queue
// Short first-in first-out queue of classified requests between the
// classifier and the serializer.
// ----------------------------------------------------------------------------
module bcut_queue #(
  parameter int Depth = bcut_pkg::FMT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  bcut_pkg::fmt_item_t wdata,
  input  logic                pop,
  output logic                empty,
  output bcut_pkg::fmt_item_t rdata
);
  import bcut_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  fmt_item_t           entries [Depth];
  logic [PtrW-1:0]     wr_ptr, rd_ptr;
  logic [CntW-1:0]     count;
  logic                do_push, do_pop;

  assign full    = (count == CntW'(Depth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== hw/rtl/bcut_back.sv =====
// ----------------------------------------------------------------------------
// bcut_back
// Walk the head request character by character into the output register.
// ----------------------------------------------------------------------------
module bcut_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  bcut_pkg::fmt_item_t q_item,
  output logic                q_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          text_char,
  output logic                last_char
);
  import bcut_pkg::*;

  logic       out_valid;
  logic [2:0] pos;
  logic [2:0] pos_next;
  logic       has_letter;
  logic [2:0] nchar;
  logic [2:0] dig_sel;
  logic [7:0] ch;
  logic       is_last;
  logic       load;

  assign has_letter = (q_item.unit != UNIT_B);
  assign nchar      = q_item.ndig + (has_letter ? 3'd3 : 3'd2);
  assign dig_sel    = pos + 3'd4 - q_item.ndig;
  assign is_last    = (pos == nchar - 3'd1);
  assign load       = !q_empty && (!out_valid || pop);
  assign q_pop      = load && is_last;
  assign pos_next   = is_last ? 3'd0 : pos + 3'd1;
  assign empty      = !out_valid;

  always_comb begin
    if (pos < q_item.ndig) begin
      ch = CHAR_ZERO + {4'd0, q_item.digits[dig_sel[1:0]]};
    end else if (pos == q_item.ndig) begin
      ch = CHAR_SPACE;
    end else if (has_letter && (pos == q_item.ndig + 3'd1)) begin
      ch = unit_letter(q_item.unit);
    end else begin
      ch = CHAR_B;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= 3'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      pos       <= pos_next;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      text_char <= ch;
      last_char <= is_last;
    end
  end

endmodule

// ===== sim/byte_count_to_unit_text_tb.sv =====
// ----------------------------------------------------------------------------
// byte_count_to_unit_text_tb
// Self-checking bench for the byte count to unit text formatter.
//
// Pushes directed corner counts and then random counts with random gaps. Pops
// characters under random stalls. Each pushed request is expanded into its
// expected character string. Every popped character is compared in order with
// the oldest expected character, on both the text and the last flag.
// ----------------------------------------------------------------------------
module byte_count_to_unit_text_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcut_pkg::*;

  localparam int CLK_HALF_NS  = 2;
  localparam int RESET_CYCLES = 3;
  localparam int RANDOM_COUNT = 355;
  // Slowest correct run: ~380 requests, each after the longest gap and with 7
  // characters, and each character held off by the longest pop stall. Allow
  // many times that.
  localparam int CYCLE_LIMIT  = 200000;
  // Extra cycles after the last character: pipeline latency plus slack.
  localparam int DRAIN_CYCLES = 24;

  localparam logic [31:0] GB_LIMIT = 32'h4000_0000;
  localparam logic [31:0] MB_LIMIT = 32'h0010_0000;
  localparam logic [31:0] KB_LIMIT = 32'h0000_0400;

  // One expected output character.
  typedef struct {
    logic [7:0] text;
    logic       last;
  } char_exp_t;

  // --------------------------------------------------------------------------
  // Scoreboard: expands each accepted request into its text and checks the
  // popped characters against that text in order.
  // --------------------------------------------------------------------------
  class unit_text_scoreboard;
    char_exp_t expected_chars[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Format the count: pick the unit, shift down, write decimal digits,
    // then a space, the unit letter if any, and a flagged 'B'.
    function void note_count(logic [31:0] count);
      unit_t      sel_unit;
      logic [31:0] quot;
      logic [7:0] digit_chars[$];
      if (count >= GB_LIMIT) begin
        sel_unit = UNIT_G;
        quot     = count >> 30;
      end else if (count >= MB_LIMIT) begin
        sel_unit = UNIT_M;
        quot     = count >> 20;
      end else if (count >= KB_LIMIT) begin
        sel_unit = UNIT_K;
        quot     = count >> 10;
      end else begin
        sel_unit = UNIT_B;
        quot     = count;
      end
      if (quot == 0) begin
        digit_chars.push_back(CHAR_ZERO);
      end else begin
        while (quot != 0) begin
          digit_chars.push_front(CHAR_ZERO + 8'(quot % 10));
          quot = quot / 10;
        end
      end
      foreach (digit_chars[i]) begin
        expected_chars.push_back('{text: digit_chars[i], last: 1'b0});
      end
      expected_chars.push_back('{text: CHAR_SPACE, last: 1'b0});
      case (sel_unit)
        UNIT_K:  expected_chars.push_back('{text: CHAR_K, last: 1'b0});
        UNIT_M:  expected_chars.push_back('{text: CHAR_M, last: 1'b0});
        UNIT_G:  expected_chars.push_back('{text: CHAR_G, last: 1'b0});
        default: ;
      endcase
      expected_chars.push_back('{text: CHAR_B, last: 1'b1});
    endfunction

    function void check_char(logic [7:0] text, logic last);
      char_exp_t want;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: text_char 0x%02h last_char %0b", text, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (text !== want.text) begin
        $error("text_char mismatch: expected 0x%02h, actual 0x%02h", want.text, text);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_char mismatch: expected %0b, actual %0b", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        push       = 1'b0;
  logic        full;
  logic [31:0] byte_count = '0;
  logic        pop        = 1'b0;
  logic        empty;
  logic [7:0]  text_char;
  logic        last_char;

  int cycle_count = 0;

  unit_text_scoreboard text_sb = new();

  always #(CLK_HALF_NS) clk = ~clk;

  byte_count_to_unit_text i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .byte_count (byte_count),
    .pop        (pop),
    .empty      (empty),
    .text_char  (text_char),
    .last_char  (last_char)
  );

  // Watchdog: give up on a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Monitors: sample both handshakes at the edge, before the block's own
  // updates land, so the bench and the block see the same values.
  always @(posedge clk) begin
    if (!rst && push && !full) begin
      text_sb.note_count(byte_count);
    end
    if (!rst && pop && !empty) begin
      text_sb.check_char(text_char, last_char);
    end
  end

  // --------------------------------------------------------------------------
  // Request driver: idle for a random gap, then hold push until accepted. With
  // no gap push stays high and only the count changes, so push is never
  // dropped and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_count(input logic [31:0] count);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    byte_count <= count;
    do @(posedge clk); while (full);
  endtask

  // Quotient for a unit: lean on the digit-count edges, else anything.
  function automatic logic [31:0] pick_quotient();
    logic [31:0] edges[8] = '{1, 9, 10, 99, 100, 999, 1000, 1023};
    if ($urandom_range(0, 1) == 0) begin
      return edges[$urandom_range(0, 7)];
    end
    return $urandom_range(1, 1023);
  endfunction

  // Random count spread over all four units, the unit thresholds and the
  // full 32-bit range so every input bit toggles.
  function automatic logic [31:0] random_count();
    logic [31:0] limits[3] = '{KB_LIMIT, MB_LIMIT, GB_LIMIT};
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return $urandom_range(0, 1023);
      3, 4:    return (pick_quotient() << 10) | ($urandom() & 32'h0000_03FF);
      5, 6:    return (pick_quotient() << 20) | ($urandom() & 32'h000F_FFFF);
      7:       return (32'($urandom_range(1, 3)) << 30) | ($urandom() & 32'h3FFF_FFFF);
      8:       return limits[$urandom_range(0, 2)] + 32'($urandom_range(0, 4)) - 32'd2;
      default: return pick_quotient() - 32'($urandom_range(0, 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Pop driver: draw a random stall before each character, then hold pop
  // until a character is taken.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    wait (!rst);
    forever begin
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    // Zero, the largest count, digit-count edges in bytes and some in KB and
    // MB, and both sides of every unit threshold.
    logic [31:0] directed[] = '{
      32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999, 32'd1000,
      32'd1023, 32'd1024, 32'd1025, 32'd10239, 32'd10240, 32'd1024000,
      32'd1047552, 32'd1048575, 32'd1048576, 32'd1048577, 32'd104857599,
      32'd1048576000, 32'd1073741823, 32'd1073741824, 32'd2147483648,
      32'd3221225472, 32'd4294967295
    };

    // Hold reset for RESET_CYCLES edges, then release it once.
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) begin
      send_count(directed[i]);
    end
    for (int n = 0; n < RANDOM_COUNT; n++) begin
      send_count(random_count());
    end
    push <= 1'b0;

    // Drain every expected character, then let the pipeline settle so a
    // stray extra character would still be caught.
    while (text_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (text_sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/bcut_pkg.sv
hw/rtl/bcut_front.sv
hw/rtl/bcut_queue.sv
hw/rtl/bcut_back.sv
hw/rtl/byte_count_to_unit_text.sv
sim/byte_count_to_unit_text_tb.sv
